>>> rtl/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int LKV_ENTRIES    = 64;
    localparam int LKV_KEY_BITS   = 64;
    localparam int LKV_VALUE_BITS = 64;

    localparam int WORD_BITS = 64;
    localparam int CFG_BITS  = 7;
    localparam int OCC_BITS  = 7;
    localparam int APB_BITS  = 32;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CFG_BITS-1:0]  t_cfg;
    typedef logic [OCC_BITS-1:0]  t_occ;
    typedef logic [APB_BITS-1:0]  t_apb;

    localparam t_cfg CAPACITY_RESET = 7'd50;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic hit;
        logic evicted;
        logic wr_en;
        logic rd_en;
    } t_flags;

endpackage

>>> rtl/lkv_ram.sv
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lkv_tags.sv
`timescale 1ns / 1ps

module lkv_tags #(
    parameter int ENTRIES  = lkv_pkg::LKV_ENTRIES,
    parameter int KEY_BITS = lkv_pkg::LKV_KEY_BITS,
    localparam int SW = $clog2(ENTRIES),
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic                  i_op,
    input  logic [KEY_BITS-1:0]   i_key,
    input  lkv_pkg::t_cfg         i_capacity,
    output lkv_pkg::t_flags       o_flags,
    output logic [SW-1:0]         o_slot,
    output logic [CW-1:0]         o_count
);

    import lkv_pkg::*;

    logic [KEY_BITS-1:0] r_key   [ENTRIES];
    logic [SW-1:0]       r_rank  [ENTRIES];
    logic [ENTRIES-1:0]  r_valid;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] victim_1h;
    logic [ENTRIES-1:0] free;
    logic [ENTRIES-1:0] free_1h;
    logic [SW-1:0]      hit_rank;
    logic [SW-1:0]      hit_slot;
    logic [SW-1:0]      free_slot;
    logic [SW-1:0]      last_rank;
    logic [CW-1:0]      cap;
    logic               hit;
    logic               is_put;
    logic               do_evict;
    logic               do_insert;
    logic               do_promote;

    always_comb begin
        if (i_capacity == '0) begin
            cap = CW'(1);
        end else if (int'(i_capacity) > ENTRIES) begin
            cap = CW'(ENTRIES);
        end else begin
            cap = CW'(i_capacity);
        end
    end

    assign last_rank = SW'(r_count - 1'b1);

    always_comb begin
        hit_rank = '0;
        hit_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_key[i] == i_key);
            victim[i] = r_valid[i] && (r_rank[i] == last_rank);
            if (match[i]) begin
                hit_rank = hit_rank | r_rank[i];
                hit_slot = hit_slot | SW'(i);
            end
        end
    end

    assign hit      = |match;
    assign is_put   = i_vld && (i_op == OP_PUT);
    assign do_evict = is_put && !hit && (r_count >= cap) && (r_count != '0);

    assign victim_1h = victim & (~victim + 1'b1) & {ENTRIES{do_evict}};
    assign free      = ~r_valid | victim_1h;
    assign free_1h   = free & (~free + 1'b1);

    always_comb begin
        free_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (free_1h[i]) begin
                free_slot = free_slot | SW'(i);
            end
        end
    end

    assign do_insert  = is_put && !hit && (|free);
    assign do_promote = i_vld && hit;
    assign n_count    = r_count - CW'(do_evict) + CW'(do_insert);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                if (do_promote) begin
                    if (match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end else if (do_insert) begin
                    if (free_1h[i]) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (victim_1h[i]) begin
                        r_valid[i] <= 1'b0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_insert && free_1h[i]) begin
                r_key[i] <= i_key;
            end
        end
    end

    assign o_flags.hit     = hit;
    assign o_flags.evicted = do_evict;
    assign o_flags.wr_en   = is_put && (hit || do_insert);
    assign o_flags.rd_en   = i_vld && (i_op == OP_GET) && hit;
    assign o_slot          = hit ? hit_slot : free_slot;
    assign o_count         = n_count;

`ifndef ASSERT_OFF
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from number of valid entries");

    a_keys_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match))
        else $error("key held in more than one entry");

    a_victim_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_evict |-> $onehot(victim))
        else $error("no unique least recent entry to evict");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_insert && !do_evict) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert without eviction did not grow occupancy");
`endif

endmodule

>>> rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Command channel: present i_operation (0 get, 1 put), i_key and i_value with
// start high; the word is taken at any edge where start is high and busy is low.
// busy stays low, so a new word may be taken on every cycle.
// Result channel: o_done is high for exactly one cycle with o_hit,
// o_read_value, o_evicted and o_occupancy; each command passes the input
// register, then lookup and update into the result register and the value
// memory's registered read port.
// Throughput is one word per cycle, set by the parallel key compare and rank
// update across all entries.
// The receiver has no way to stall; it must take each result as it comes.
// Configuration: APB register capacity at address 0 (reset 50); write it only
// while no command is in flight.
// Reset (synchronous, active low) empties the cache and drops any word in
// flight; stored keys and values are left as they are and never read until
// written again.
module lru_key_value_cache #(
    parameter int ENTRIES    = lkv_pkg::LKV_ENTRIES,
    parameter int KEY_BITS   = lkv_pkg::LKV_KEY_BITS,
    parameter int VALUE_BITS = lkv_pkg::LKV_VALUE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_operation,
    input  lkv_pkg::t_word  i_key,
    input  lkv_pkg::t_word  i_value,
    output logic            o_done,
    output logic            o_hit,
    output lkv_pkg::t_word  o_read_value,
    output logic            o_evicted,
    output lkv_pkg::t_occ   o_occupancy,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  lkv_pkg::t_apb   pwdata,
    output lkv_pkg::t_apb   prdata,
    output logic            pready
);

    import lkv_pkg::*;

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic                  accept;
    logic                  r_vld;
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    t_cfg                  r_capacity;

    t_flags                flags;
    logic [SW-1:0]         slot;
    logic [CW-1:0]         count;
    logic [VALUE_BITS-1:0] rdata;

    logic                  r_done;
    logic                  r_hit;
    logic                  r_evicted;
    logic                  r_rd;
    t_occ                  r_occ;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= i_key[KEY_BITS-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CFG_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? t_apb'(r_capacity) : '0;

    lkv_tags #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_tags (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld),
        .i_op       (r_op),
        .i_key      (r_key),
        .i_capacity (r_capacity),
        .o_flags    (flags),
        .o_slot     (slot),
        .o_count    (count)
    );

    lkv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_values (
        .i_clk   (i_clk),
        .i_we    (flags.wr_en),
        .i_waddr (slot),
        .i_wdata (r_value),
        .i_re    (flags.rd_en),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit     <= flags.hit;
        r_evicted <= flags.evicted;
        r_rd      <= flags.rd_en;
        r_occ     <= t_occ'(count);
    end

    assign o_done       = r_done;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;
    assign o_occupancy  = r_occ;
    assign o_read_value = r_rd ? t_word'(rdata) : '0;

endmodule
